>>> rtl/msfm_pkg.sv
`default_nettype none

package msfm_pkg;

  localparam int MAX_ARITY    = 3;
  localparam int MAX_LABELS   = 8;
  localparam int LAB_W        = $clog2(MAX_LABELS);
  localparam int CNT_W        = $clog2(MAX_LABELS + 1);
  localparam int VAR_W        = 2;
  localparam int ENERGY_DEPTH = 512;
  localparam int EIDX_W       = $clog2(ENERGY_DEPTH);
  localparam int DATA_W       = 32;
  localparam int SUM_W        = DATA_W + 2;
  localparam int CAND_W       = DATA_W + 3;
  localparam int CFG_W        = 32;
  localparam int PADDR_W      = 4;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic [LAB_W-1:0] lab_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_LOAD_ENERGY = 2'd0,
    ACT_LOAD_MSG    = 2'd1,
    ACT_COMPUTE     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_ARITY         = 2'd0,
    REG_LABELS_FIRST  = 2'd1,
    REG_LABELS_SECOND = 2'd2,
    REG_LABELS_THIRD  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

  // Zero arity acts as unary; larger values clamp to the slot count.
  function automatic logic [VAR_W-1:0] eff_arity(input logic [VAR_W-1:0] a);
    if (a == '0) begin
      return VAR_W'(1);
    end else if (a > MAX_ARITY) begin
      return VAR_W'(MAX_ARITY);
    end
    return a;
  endfunction

  function automatic cnt_t eff_labels(input logic [3:0] n);
    if (n == '0) begin
      return CNT_W'(1);
    end else if (n > MAX_LABELS) begin
      return CNT_W'(MAX_LABELS);
    end
    return CNT_W'(n);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [CAND_W-1:0] x);
    if (x > CAND_W'(Q_MAX)) begin
      return Q_MAX;
    end else if (x < CAND_W'(Q_MIN)) begin
      return Q_MIN;
    end
    return x[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/min_sum_factor_message.sv
// Loads: a load can follow any load in the next cycle.
// Compute: a walk of P labelings, P being the product of the active label counts (one
// energy memory read per cycle), a drain of the accumulate pipeline, then per result a
// minimum bank read, an output load and the transfer, which an output stall can hold.
// One compute at a time: in_stall is high from compute transfer to the last result.
// Reset: control state cleared, registers back to 2; the memories keep their contents.
`default_nettype none

module min_sum_factor_message (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            action,
  input  wire logic [msfm_pkg::VAR_W-1:0]            var_pos,
  input  wire logic [msfm_pkg::EIDX_W-1:0]           entry_index,
  input  wire logic signed [msfm_pkg::DATA_W-1:0]    value,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [msfm_pkg::VAR_W-1:0]                 out_var,
  output logic [msfm_pkg::LAB_W-1:0]                 out_label,
  output logic signed [msfm_pkg::DATA_W-1:0]         message,
  output logic                                       last,
  // configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [msfm_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [msfm_pkg::CFG_W-1:0]            pwdata,
  output logic [msfm_pkg::CFG_W-1:0]                 prdata,
  output logic                                       pready
);

  localparam int NA = msfm_pkg::MAX_ARITY;
  localparam int NL = msfm_pkg::MAX_LABELS;
  localparam int DW = msfm_pkg::DATA_W;

  msfm_pkg::state_t state, state_next;

  // Control decoded from the state register.
  logic issue;       // walk stage issues one labeling this cycle
  logic emit_mode;   // minimum banks addressed by the emit counters
  logic emit_load;   // capture bank data into the output register

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [msfm_pkg::VAR_W-1:0] cfg_arity;
  logic [3:0]                 cfg_labels [NA];
  logic                       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_arity <= msfm_pkg::VAR_W'(2);
      for (int i = 0; i < NA; i++) begin
        cfg_labels[i] <= 4'd2;
      end
    end else if (cfg_we) begin
      case (msfm_pkg::reg_idx_t'(paddr[3:2]))
        msfm_pkg::REG_ARITY:         cfg_arity     <= pwdata[msfm_pkg::VAR_W-1:0];
        msfm_pkg::REG_LABELS_FIRST:  cfg_labels[0] <= pwdata[3:0];
        msfm_pkg::REG_LABELS_SECOND: cfg_labels[1] <= pwdata[3:0];
        msfm_pkg::REG_LABELS_THIRD:  cfg_labels[2] <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (msfm_pkg::reg_idx_t'(paddr[3:2]))
      msfm_pkg::REG_ARITY:         prdata = msfm_pkg::CFG_W'(cfg_arity);
      msfm_pkg::REG_LABELS_FIRST:  prdata = msfm_pkg::CFG_W'(cfg_labels[0]);
      msfm_pkg::REG_LABELS_SECOND: prdata = msfm_pkg::CFG_W'(cfg_labels[1]);
      msfm_pkg::REG_LABELS_THIRD:  prdata = msfm_pkg::CFG_W'(cfg_labels[2]);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic energy_we;
  logic msg_we;
  logic compute_go;

  assign in_xfer    = in_valid && !in_stall;
  assign energy_we  = in_xfer && (action == msfm_pkg::ACT_LOAD_ENERGY);
  // Drop message loads that fall outside the slot or label range.
  assign msg_we     = in_xfer && (action == msfm_pkg::ACT_LOAD_MSG)
                      && (var_pos < NA) && (entry_index < NL);
  assign compute_go = in_xfer && (action == msfm_pkg::ACT_COMPUTE);

  // ---------------------------------------------------------------------------
  // Compute setup: effective arity and top label of every slot, latched per compute.
  // Unused slots get a single label so the odometer treats them as fixed at zero.
  // ---------------------------------------------------------------------------
  logic [msfm_pkg::VAR_W-1:0] arity;
  msfm_pkg::lab_t             lab_top [NA];
  logic [msfm_pkg::VAR_W-1:0] arity_eff;

  assign arity_eff = msfm_pkg::eff_arity(cfg_arity);

  always_ff @(posedge clk) begin
    if (compute_go) begin
      arity <= arity_eff;
      for (int i = 0; i < NA; i++) begin
        lab_top[i] <= (i < arity_eff)
                      ? msfm_pkg::LAB_W'(msfm_pkg::eff_labels(cfg_labels[i]) - 1)
                      : '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Labeling walk. Row-major with the last slot fastest means the flat energy
  // index is simply a running count.
  // ---------------------------------------------------------------------------
  msfm_pkg::lab_t              lab      [NA];
  msfm_pkg::lab_t              lab_next [NA];
  logic [msfm_pkg::EIDX_W-1:0] flat;
  logic                        walk_last;

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = NA - 1; i >= 0; i--) begin
      lab_next[i] = lab[i];
      if (carry) begin
        if (lab[i] == lab_top[i]) begin
          lab_next[i] = '0;
        end else begin
          lab_next[i] = lab[i] + 1'b1;
          carry       = 1'b0;
        end
      end
    end
  end

  always_comb begin
    walk_last = 1'b1;
    for (int i = 0; i < NA; i++) begin
      if (lab[i] != lab_top[i]) begin
        walk_last = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (compute_go) begin
      flat <= '0;
      for (int i = 0; i < NA; i++) begin
        lab[i] <= '0;
      end
    end else if (issue) begin
      flat <= flat + 1'b1;
      lab  <= lab_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Energy memory: written by loads, read once per walk cycle.
  // ---------------------------------------------------------------------------
  logic [DW-1:0]        energy_mem [msfm_pkg::ENERGY_DEPTH];
  logic signed [DW-1:0] energy_q;

  always_ff @(posedge clk) begin
    if (energy_we) begin
      energy_mem[entry_index] <= value;
    end
    energy_q <= energy_mem[flat];
  end

  // ---------------------------------------------------------------------------
  // Incoming message banks, one per slot, each read at that slot's label.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] msg_q [NA];

  for (genvar g = 0; g < NA; g++) begin : g_msg
    logic [DW-1:0] mem [NL];

    always_ff @(posedge clk) begin
      if (msg_we && (var_pos == msfm_pkg::VAR_W'(g))) begin
        mem[entry_index[msfm_pkg::LAB_W-1:0]] <= value;
      end
      msg_q[g] <= mem[lab[g]];
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate pipeline
  //   s1: energy and messages arrive; form the other-slot sums
  //   s2: add energy and saturate; read the minimum banks
  //   s3: compare against the running minimum and write it back
  // ---------------------------------------------------------------------------
  logic                        s1_valid, s2_valid, s3_valid;
  msfm_pkg::lab_t              s1_lab [NA];
  msfm_pkg::lab_t              s2_lab [NA];
  msfm_pkg::lab_t              s3_lab [NA];
  logic signed [msfm_pkg::SUM_W-1:0] others    [NA];
  logic signed [msfm_pkg::SUM_W-1:0] s2_others [NA];
  logic signed [DW-1:0]        s2_energy;
  logic signed [DW-1:0]        s3_cand [NA];

  // Build each sum directly from the other slots; inactive slots add nothing.
  always_comb begin
    for (int v = 0; v < NA; v++) begin
      others[v] = '0;
      for (int i = 0; i < NA; i++) begin
        if ((i != v) && (i < arity)) begin
          others[v] = others[v] + msfm_pkg::SUM_W'(msg_q[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_lab    <= lab;
    s2_lab    <= s1_lab;
    s3_lab    <= s2_lab;
    s2_energy <= energy_q;
    s2_others <= others;
    for (int v = 0; v < NA; v++) begin
      s3_cand[v] <= msfm_pkg::sat_q(msfm_pkg::CAND_W'(s2_energy)
                                    + msfm_pkg::CAND_W'(s2_others[v]));
    end
  end

  // ---------------------------------------------------------------------------
  // Minimum banks with per-entry valid bits (invalid reads as the largest value)
  // and a one-entry forward of the previous write, which the read issued in the
  // same cycle as that write cannot see yet.
  // ---------------------------------------------------------------------------
  logic [NL-1:0]               min_ok   [NA];
  logic signed [DW-1:0]        min_q    [NA];
  logic signed [DW-1:0]        min_cur  [NA];
  logic signed [DW-1:0]        min_new  [NA];
  logic [NA-1:0]               min_we;
  logic [NA-1:0]               fwd_valid;
  msfm_pkg::lab_t              fwd_lab  [NA];
  logic signed [DW-1:0]        fwd_data [NA];

  logic [msfm_pkg::VAR_W-1:0]  ev;
  msfm_pkg::lab_t              el;
  logic                        emit_last;

  always_comb begin
    for (int v = 0; v < NA; v++) begin
      min_we[v] = s3_valid && (v < arity);
      if (fwd_valid[v] && (fwd_lab[v] == s3_lab[v])) begin
        min_cur[v] = fwd_data[v];
      end else if (min_ok[v][s3_lab[v]]) begin
        min_cur[v] = min_q[v];
      end else begin
        min_cur[v] = msfm_pkg::Q_MAX;
      end
      min_new[v] = (s3_cand[v] < min_cur[v]) ? s3_cand[v] : min_cur[v];
    end
  end

  for (genvar g = 0; g < NA; g++) begin : g_min
    logic [DW-1:0]  mem [NL];
    msfm_pkg::lab_t rd_addr;

    assign rd_addr = emit_mode ? el : s2_lab[g];

    always_ff @(posedge clk) begin
      if (min_we[g]) begin
        mem[s3_lab[g]] <= min_new[g];
      end
      min_q[g] <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= '0;
      for (int v = 0; v < NA; v++) begin
        min_ok[v] <= '0;
      end
    end else begin
      fwd_valid <= min_we;
      for (int v = 0; v < NA; v++) begin
        if (compute_go) begin
          min_ok[v] <= '0;
        end else if (min_we[v]) begin
          min_ok[v][s3_lab[v]] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_lab  <= s3_lab;
    fwd_data <= min_new;
  end

  // ---------------------------------------------------------------------------
  // Result emission: slot order, then label order.
  // ---------------------------------------------------------------------------
  assign emit_last = (ev == arity - 1'b1) && (el == lab_top[ev]);

  always_ff @(posedge clk) begin
    if (compute_go) begin
      ev <= '0;
      el <= '0;
    end else if (out_valid && !out_stall && !emit_last) begin
      if (el == lab_top[ev]) begin
        ev <= ev + 1'b1;
        el <= '0;
      end else begin
        el <= el + 1'b1;
      end
    end
  end

  // Hold the output register until the transfer; it only loads in a fresh state.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_var   <= ev;
      out_label <= el;
      message   <= min_q[ev];
      last      <= emit_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msfm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      msfm_pkg::ST_IDLE: begin
        if (compute_go) begin
          state_next = msfm_pkg::ST_WALK;
        end
      end
      msfm_pkg::ST_WALK: begin
        if (walk_last) begin
          state_next = msfm_pkg::ST_DRAIN;
        end
      end
      msfm_pkg::ST_DRAIN: begin
        // Wait until the last minimum is written back.
        if (!(s1_valid || s2_valid || s3_valid)) begin
          state_next = msfm_pkg::ST_EMIT_RD;
        end
      end
      msfm_pkg::ST_EMIT_RD: begin
        state_next = msfm_pkg::ST_EMIT_LD;
      end
      msfm_pkg::ST_EMIT_LD: begin
        state_next = msfm_pkg::ST_EMIT_HOLD;
      end
      msfm_pkg::ST_EMIT_HOLD: begin
        if (!out_stall) begin
          state_next = emit_last ? msfm_pkg::ST_IDLE : msfm_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = msfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    issue     = 1'b0;
    emit_mode = 1'b0;
    emit_load = 1'b0;
    out_valid = 1'b0;
    case (state)
      msfm_pkg::ST_IDLE:      in_stall = 1'b0;
      msfm_pkg::ST_WALK:      issue    = 1'b1;
      msfm_pkg::ST_DRAIN:     ;
      msfm_pkg::ST_EMIT_RD:   emit_mode = 1'b1;
      msfm_pkg::ST_EMIT_LD: begin
        emit_mode = 1'b1;
        emit_load = 1'b1;
      end
      msfm_pkg::ST_EMIT_HOLD: begin
        emit_mode = 1'b1;
        out_valid = 1'b1;
      end
      default: ;
    endcase
    if (state inside {msfm_pkg::ST_EMIT_RD, msfm_pkg::ST_EMIT_LD,
                      msfm_pkg::ST_EMIT_HOLD}) begin
      in_stall = 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/msfm_checker.sv
`default_nettype none

module msfm_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [msfm_pkg::VAR_W-1:0]         out_var,
  input wire logic [msfm_pkg::LAB_W-1:0]         out_label,
  input wire logic signed [msfm_pkg::DATA_W-1:0] message,
  input wire logic                               last
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(message) && $stable(out_var)
                               && $stable(out_label) && $stable(last))
    else $error("stalled result changed");

  // No input is taken while results of a compute are pending.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  // Each result transfer is followed by a gap while the next entry is read.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated after transfer");

  // Reset leaves the block idle with no result.
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind min_sum_factor_message msfm_checker u_msfm_checker (.*);

`default_nettype wire
